@@ src/sha256md_pkg.sv @@
package sha256md_pkg;

  typedef logic [31:0] word_t;

  // control from the top level sequencer to the round datapath
  typedef struct packed {
    logic load;    // shift a chaining word into the working variables
    logic round;   // run one compression round
    logic rotate;  // rotate the working variables for the final add
  } round_ctl_t;

  // initial hash values
  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

@@ src/sha256_message_digest_core.sv @@
// SHA-256 over a byte stream. Each message byte is one beat on the slave side
// and is taken while s_tready is high; the 64th byte of a block starts a
// compression (load the chaining values and prime the schedule memory
// reads, run 64 rounds, add back into the chaining memory), during which
// s_tready is low. A beat with tlast set closes the message: padding runs
// one byte per cycle up to byte 56 (crossing into an extra block when fewer
// than 9 bytes are left), the bit length is written high word first, one
// more compression follows, and the eight digest words then leave on the
// master side, each read from the chaining memory and put out once the
// previous one is taken, word 0 first, tlast on word 7. After reset and
// after every digest the block writes the initial hash values into the
// chaining memory before it takes a beat. The length saturates at 2^64-1 bits.
module sha256_message_digest_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PAD, ST_LEN, ST_LOAD, ST_ROUND, ST_ADD, ST_READ, ST_PUT
  } state_t;

  state_t      state;
  logic [5:0]  cnt;
  logic [5:0]  pos;
  logic [63:0] total_bits;
  logic        pad_first;
  logic        end_pend;
  logic        final_blk;
  logic [23:0] wacc;

  // schedule memory and its read side
  sha256md_pkg::word_t sched_mem [16];
  sha256md_pkg::word_t rd_a;
  sha256md_pkg::word_t rd_b;
  sha256md_pkg::word_t prev_a;
  sha256md_pkg::word_t w_cur;
  sha256md_pkg::word_t w_prev;
  sha256md_pkg::word_t w_new;
  logic                s_we;
  logic [3:0]          s_wa;
  sha256md_pkg::word_t s_wd;
  logic [3:0]          s_ra;
  logic [3:0]          s_rb;
  logic [5:0]          su;
  logic                sched_calc;

  // chaining memory
  sha256md_pkg::word_t chain_mem [8];
  sha256md_pkg::word_t rd_c;
  logic                c_we;
  logic [2:0]          c_wa;
  sha256md_pkg::word_t c_wd;
  logic [2:0]          c_ra;

  // byte path
  logic                push_en;
  logic [7:0]          push_byte;
  logic                push_full;
  logic [5:0]          pos_inc;
  sha256md_pkg::word_t push_word;

  sha256md_pkg::round_ctl_t ctl;
  sha256md_pkg::word_t      head;

  assign s_tready = (state == ST_IDLE);

  // byte source: message beats or padding
  always_comb begin
    push_en   = 1'b0;
    push_byte = s_tdata;
    if (state == ST_IDLE) begin
      push_en = s_tvalid && s_tuser;
    end else if (state == ST_PAD) begin
      push_en   = 1'b1;
      push_byte = pad_first ? 8'h80 : 8'h00;
    end
  end

  assign push_full = (pos == 6'd63);
  assign pos_inc   = pos + 6'd1;
  assign push_word = {wacc, push_byte};

  // schedule expansion runs one word ahead of the rounds
  assign su         = (state == ST_ROUND) ? (cnt + 6'd1) : 6'd0;
  assign sched_calc = ((state == ST_LOAD) && (cnt == 6'd9)) ||
                      ((state == ST_ROUND) && (cnt != 6'd63));
  assign w_new      = (su[5:4] == 2'b00) ? prev_a :
                      sha256md_pkg::small_sigma1(w_prev) + rd_b +
                      sha256md_pkg::small_sigma0(rd_a) + prev_a;
  assign s_ra       = (state == ST_LOAD) ? (cnt[3:0] - 4'd7) : (su[3:0] + 4'd2);
  assign s_rb       = su[3:0] + 4'd10;

  // schedule write port
  always_comb begin
    s_we = 1'b0;
    s_wa = pos[5:2];
    s_wd = push_word;
    if (push_en && (pos[1:0] == 2'b11)) begin
      s_we = 1'b1;
    end else if (state == ST_LEN) begin
      s_we = 1'b1;
      s_wa = {3'b111, cnt[0]};
      s_wd = cnt[0] ? total_bits[31:0] : total_bits[63:32];
    end else if (sched_calc && (su[5:4] != 2'b00)) begin
      s_we = 1'b1;
      s_wa = su[3:0];
      s_wd = w_new;
    end
  end

  // schedule memory, two read ports
  always_ff @(posedge clk) begin
    if (s_we) begin
      sched_mem[s_wa] <= s_wd;
    end
    rd_a   <= sched_mem[s_ra];
    rd_b   <= sched_mem[s_rb];
    prev_a <= rd_a;
    if (sched_calc) begin
      w_cur  <= w_new;
      w_prev <= w_cur;
    end
  end

  // chaining memory ports
  always_comb begin
    c_we = 1'b0;
    c_wa = cnt[2:0];
    c_wd = sha256md_pkg::InitHash[cnt[2:0]];
    if (state == ST_INIT) begin
      c_we = 1'b1;
    end else if ((state == ST_ADD) && (cnt != 6'd0)) begin
      c_we = 1'b1;
      c_wa = cnt[2:0] - 3'd1;
      c_wd = rd_c + head;
    end
    c_ra = (state == ST_LOAD) ? ~cnt[2:0] : cnt[2:0];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      chain_mem[c_wa] <= c_wd;
    end
    rd_c <= chain_mem[c_ra];
  end

  // round datapath control
  always_comb begin
    ctl.load   = (state == ST_LOAD) && (cnt != 6'd0) && (cnt <= 6'd8);
    ctl.round  = (state == ST_ROUND);
    ctl.rotate = (state == ST_ADD) && (cnt != 6'd0);
  end

  sha256md_round u_round (
    .clk       (clk),
    .ctl       (ctl),
    .load_word (rd_c),
    .w_t       (w_cur),
    .k_t       (sha256md_pkg::RoundK[cnt]),
    .head      (head)
  );

  // byte packing into words
  always_ff @(posedge clk) begin
    if (push_en) begin
      wacc <= {wacc[15:0], push_byte};
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      pos        <= '0;
      total_bits <= '0;
      pad_first  <= 1'b0;
      end_pend   <= 1'b0;
      final_blk  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // beat taken; the put state loads the next one itself
      if (m_tvalid && m_tready && (state != ST_PUT)) begin
        m_tvalid <= 1'b0;
      end
      if (push_en) begin
        pos <= pos_inc;
      end
      case (state)
        ST_INIT: begin
          pos        <= '0;
          total_bits <= '0;
          pad_first  <= 1'b0;
          end_pend   <= 1'b0;
          final_blk  <= 1'b0;
          if (cnt == 6'd7) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              // length saturates once it cannot take another byte
              total_bits <= (&total_bits[63:3]) ? '1 : (total_bits + 64'd8);
            end
            if (s_tuser && push_full) begin
              state     <= ST_LOAD;
              cnt       <= '0;
              end_pend  <= s_tlast;
              pad_first <= 1'b1;
            end else if (s_tlast) begin
              state     <= ST_PAD;
              end_pend  <= 1'b1;
              pad_first <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (push_full) begin
            state <= ST_LOAD;
            cnt   <= '0;
          end else if (pos_inc == 6'd56) begin
            state <= ST_LEN;
            cnt   <= '0;
          end
        end
        ST_LEN: begin
          if (cnt == 6'd1) begin
            state     <= ST_LOAD;
            cnt       <= '0;
            pos       <= '0;
            final_blk <= 1'b1;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_LOAD: begin
          if (cnt == 6'd9) begin
            state <= ST_ROUND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_ROUND: begin
          if (cnt == 6'd63) begin
            state <= ST_ADD;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_ADD: begin
          if (cnt == 6'd8) begin
            cnt <= '0;
            if (final_blk) begin
              state <= ST_READ;
            end else if (end_pend) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        ST_READ: begin
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= rd_c;
            m_tuser  <= cnt[2:0];
            m_tlast  <= (cnt[2:0] == 3'd7);
            if (cnt[2:0] == 3'd7) begin
              state <= ST_INIT;
              cnt   <= '0;
            end else begin
              state <= ST_READ;
              cnt   <= cnt + 6'd1;
            end
          end
        end
        default: begin
          state <= ST_INIT;
          cnt   <= '0;
        end
      endcase
    end
  end

endmodule

@@ src/sha256md_round.sv @@
module sha256md_round (
  input  logic                    clk,
  input  sha256md_pkg::round_ctl_t ctl,
  input  sha256md_pkg::word_t     load_word,
  input  sha256md_pkg::word_t     w_t,
  input  sha256md_pkg::word_t     k_t,
  output sha256md_pkg::word_t     head
);

  // working variables a..h
  sha256md_pkg::word_t wv [8];
  sha256md_pkg::word_t t1;
  sha256md_pkg::word_t t2;
  sha256md_pkg::word_t ch;
  sha256md_pkg::word_t maj;

  // round function
  always_comb begin
    ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1  = wv[7] + sha256md_pkg::big_sigma1(wv[4]) + ch + k_t + w_t;
    t2  = sha256md_pkg::big_sigma0(wv[0]) + maj;
  end

  // load, round or rotate
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      wv[0] <= load_word;
      for (int i = 1; i < 8; i++) begin
        wv[i] <= wv[i-1];
      end
    end else if (ctl.round) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end else if (ctl.rotate) begin
      for (int i = 0; i < 7; i++) begin
        wv[i] <= wv[i+1];
      end
      wv[7] <= wv[0];
    end
  end

  assign head = wv[0];

endmodule
